FILE: sv/sparse_csc_matrix_oracle_defines.svh
// Assertion macros used by the checker file.
`ifndef SPARSE_CSC_MATRIX_ORACLE_DEFINES_SVH
`define SPARSE_CSC_MATRIX_ORACLE_DEFINES_SVH

// same-cycle implication, idle during reset
`define CSC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csc check failed");

// next-cycle implication, idle during reset
`define CSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csc check failed");

`endif

FILE: sv/csc_pkg.sv
package csc_pkg;

   localparam int DIM_DEFAULT = 64;
   localparam int NNZ_DEFAULT = 1024;
   localparam int EMIT_LIMIT  = 64;

   localparam int OP_W  = 3;
   localparam int COL_W = 7;
   localparam int ROW_W = 6;
   localparam int SLOT_W = 10;
   localparam int PTR_W = 11;
   localparam int VAL_W = 32;
   localparam int ACC_W = 48;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 3;

   localparam logic [OP_W-1:0] OP_SET_START  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_ENTRY  = 3'd1;
   localparam logic [OP_W-1:0] OP_GET_ENTRY  = 3'd2;
   localparam logic [OP_W-1:0] OP_GET_COLUMN = 3'd3;
   localparam logic [OP_W-1:0] OP_ADD_COLUMN = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;
   localparam logic [OP_W-1:0] OP_READ_ACC   = 3'd6;
   localparam logic [OP_W-1:0] OP_NOP        = 3'd7;

   typedef logic signed [ACC_W-1:0] acc_type;

   localparam acc_type ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam acc_type ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic signed [VAL_W-1:0] value;
   } nz_type;

   typedef struct packed {
      acc_type sum;
      logic    clip;
   } mac_res_type;

endpackage

FILE: sv/csc_ram.sv
module csc_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 64)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rdata_ff;

endmodule

FILE: sv/csc_mac.sv
module csc_mac
   import csc_pkg::*;
   (input  logic                    clock,
    input  logic signed [VAL_W-1:0] entry,
    input  logic signed [VAL_W-1:0] x,
    input  acc_type                 acc,
    output mac_res_type             res);

   logic signed [2*VAL_W-1:0] product_ff;
   logic signed [2*VAL_W-1:0] biased;
   logic signed [ACC_W-1:0]   rounded;
   logic signed [ACC_W:0]     sum_wide;
   logic                      over;

   always_ff @(posedge clock) begin
      product_ff <= entry * x;
   end

   always_comb begin
      biased   = product_ff + 64'sd32768;
      rounded  = biased[2*VAL_W-1:16];
      sum_wide = {acc[ACC_W-1], acc} + {rounded[ACC_W-1], rounded};
      over     = sum_wide[ACC_W] != sum_wide[ACC_W-1];
      res.clip = over;
      if (over) begin
         res.sum = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         res.sum = sum_wide[ACC_W-1:0];
      end
   end

endmodule

FILE: sv/sparse_csc_matrix_oracle.sv
// Sparse square matrix store in compressed-column form with a dense accumulator.
// req channel: one transaction per command; req_tuser carries the opcode, req_tdata
// the operands. Loads (set start, set entry), clear and no-op finish in the cycle
// they are taken and produce nothing on rsp.
// Entry query, column query and scaled-column add read the two column start
// pointers (states P0, P1, P2) and then walk the column one stored entry at a
// time through a single read port of the nonzero memory: states RD and USE per
// entry for queries, RD, USE and ADD for an add (multiply, then add-and-saturate
// in the one shared MAC). A column query gives one rsp transaction per entry,
// at most 64. Read accumulator answers from state ACC. req_tready is high only
// while the sequencer is idle, so one command is in work at a time.
// rsp has an output register: an idle block takes the next command while the
// last result waits; when rsp_tready is low the sequencer holds at its next
// result until the register frees.
// Reset clears the sequencer, the output register, the clip flag and the
// accumulator valid bits (the accumulator reads as zero); the matrix memories
// are undefined until loaded.
module sparse_csc_matrix_oracle
   import csc_pkg::*;
   #(parameter int DIM          = DIM_DEFAULT,
     parameter int MAX_NONZEROS = NNZ_DEFAULT)
   (input  logic                  clock,
    input  logic                  reset,
    input  logic                  req_tvalid,
    output logic                  req_tready,
    // column, row, slot, pointer, entry_value, x_value
    input  logic [REQ_DATA_W-1:0] req_tdata,
    // opcode
    input  logic [OP_W-1:0]       req_tuser,
    output logic                  rsp_tvalid,
    input  logic                  rsp_tready,
    // out_row, out_value
    output logic [RSP_DATA_W-1:0] rsp_tdata,
    // found, empty_res, saturated
    output logic [RSP_USER_W-1:0] rsp_tuser,
    output logic                  rsp_tlast);

   localparam int CW = $clog2(DIM + 1);
   localparam int RW = $clog2(DIM);
   localparam int NW = $clog2(MAX_NONZEROS);
   localparam int PW = ($clog2(MAX_NONZEROS + 1) > PTR_W) ? $clog2(MAX_NONZEROS + 1) : PTR_W;
   localparam logic [PW-1:0] NNZ_P = PW'(MAX_NONZEROS);
   localparam logic [5:0] CNT_LAST = 6'(EMIT_LIMIT - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_P0   = 3'd1;
   localparam logic [2:0] S_P1   = 3'd2;
   localparam logic [2:0] S_P2   = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_USE  = 3'd5;
   localparam logic [2:0] S_ADD  = 3'd6;
   localparam logic [2:0] S_ACC  = 3'd7;

   logic [OP_W-1:0]         in_op;
   logic [COL_W-1:0]        in_col;
   logic [ROW_W-1:0]        in_row;
   logic [SLOT_W-1:0]       in_slot;
   logic [PTR_W-1:0]        in_ptr;
   logic signed [VAL_W-1:0] in_ev;
   logic signed [VAL_W-1:0] in_xv;
   logic [31:0]             in_col32, in_row32, in_slot32;

   logic [2:0]              state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic signed [VAL_W-1:0] x_ff, x_in;
   logic                    colbig_ff, colbig_in;
   logic [PW-1:0]           i_ff, i_in;
   logic [PW-1:0]           hi_ff, hi_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic [RW-1:0]           acc_addr_ff, acc_addr_in;
   logic                    accv_ff, accv_in;
   logic                    rowok_ff, rowok_in;
   logic                    clip_ff, clip_in;
   logic [DIM-1:0]          accvalid_ff, accvalid_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]        rsp_row_ff, rsp_row_in;
   acc_type                 rsp_val_ff, rsp_val_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   logic                    cs_we;
   logic [CW-1:0]           cs_wa, cs_ra;
   logic [PTR_W-1:0]        cs_rdata;
   logic                    nz_we;
   logic [NW-1:0]           nz_wa, nz_ra;
   nz_type                  nz_wd, nz_rd;
   logic [$bits(nz_type)-1:0] nz_rdata;
   logic                    acc_we;
   logic [RW-1:0]           acc_ra;
   acc_type                 acc_rdata;
   acc_type                 mac_acc;
   mac_res_type             mac_res;

   logic                    can_emit;
   logic [31:0]             col32_ff, colp32_ff, nzrow32;
   logic [PW-1:0]           end_p, hi_p, i_next;
   logic                    last_i;
   acc_type                 nz_val48;

   assign in_op     = req_tuser;
   assign in_col    = req_tdata[6:0];
   assign in_row    = req_tdata[12:7];
   assign in_slot   = req_tdata[22:13];
   assign in_ptr    = req_tdata[33:23];
   assign in_ev     = req_tdata[65:34];
   assign in_xv     = req_tdata[97:66];
   assign in_col32  = {25'd0, in_col};
   assign in_row32  = {26'd0, in_row};
   assign in_slot32 = {22'd0, in_slot};

   assign col32_ff  = {25'd0, col_ff};
   assign colp32_ff = col32_ff + 32'd1;
   assign nz_rd     = nz_type'(nz_rdata);
   assign nzrow32   = {26'd0, nz_rd.row};
   assign nz_val48  = {{(ACC_W-VAL_W){nz_rd.value[VAL_W-1]}}, nz_rd.value};
   assign i_next    = i_ff + 1'b1;
   assign last_i    = i_next == hi_ff;
   assign end_p     = PW'(cs_rdata);
   assign hi_p      = (end_p > NNZ_P) ? NNZ_P : end_p;
   assign can_emit  = !rsp_valid_ff || rsp_tready;
   assign nz_wd     = '{row: in_row, value: in_ev};
   assign mac_acc   = accv_ff ? acc_rdata : '0;

   csc_ram #(.WIDTH(PTR_W), .DEPTH(DIM + 1)) u_starts (
      .clock(clock), .wr_en(cs_we), .wr_addr(cs_wa), .wr_data(in_ptr),
      .rd_addr(cs_ra), .rd_data(cs_rdata));

   csc_ram #(.WIDTH($bits(nz_type)), .DEPTH(MAX_NONZEROS)) u_nz (
      .clock(clock), .wr_en(nz_we), .wr_addr(nz_wa), .wr_data(nz_wd),
      .rd_addr(nz_ra), .rd_data(nz_rdata));

   csc_ram #(.WIDTH(ACC_W), .DEPTH(DIM)) u_acc (
      .clock(clock), .wr_en(acc_we), .wr_addr(acc_addr_ff), .wr_data(mac_res.sum),
      .rd_addr(acc_ra), .rd_data(acc_rdata));

   csc_mac u_mac (
      .clock(clock), .entry(nz_rd.value), .x(x_ff), .acc(mac_acc), .res(mac_res));

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      x_in        = x_ff;
      colbig_in   = colbig_ff;
      i_in        = i_ff;
      hi_in       = hi_ff;
      cnt_in      = cnt_ff;
      acc_addr_in = acc_addr_ff;
      accv_in     = accv_ff;
      rowok_in    = rowok_ff;
      clip_in     = clip_ff;
      accvalid_in = accvalid_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_found_in = rsp_found_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_sat_in   = rsp_sat_ff;

      cs_we  = 1'b0;
      cs_wa  = in_col32[CW-1:0];
      cs_ra  = colp32_ff[CW-1:0];
      nz_we  = 1'b0;
      nz_wa  = in_slot32[NW-1:0];
      nz_ra  = i_ff[NW-1:0];
      acc_we = 1'b0;
      acc_ra = acc_addr_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = in_op;
               col_in    = in_col;
               row_in    = in_row;
               x_in      = in_xv;
               colbig_in = in_col32 >= DIM;
               case (in_op)
                  OP_SET_START: begin
                     cs_we = in_col32 <= DIM;
                  end
                  OP_SET_ENTRY: begin
                     nz_we = in_slot32 < MAX_NONZEROS;
                  end
                  OP_GET_ENTRY, OP_GET_COLUMN, OP_ADD_COLUMN: begin
                     state_in = S_P0;
                  end
                  OP_CLEAR: begin
                     accvalid_in = '0;
                     clip_in     = 1'b0;
                  end
                  OP_READ_ACC: begin
                     acc_ra      = in_row32[RW-1:0];
                     acc_addr_in = in_row32[RW-1:0];
                     rowok_in    = in_row32 < DIM;
                     accv_in     = accvalid_ff[in_row32[RW-1:0]];
                     state_in    = S_ACC;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_P0: begin
            cs_ra    = col32_ff[CW-1:0];
            state_in = S_P1;
         end
         S_P1: begin
            i_in     = PW'(cs_rdata);
            state_in = S_P2;
         end
         S_P2: begin
            hi_in  = hi_p;
            cnt_in = '0;
            if (colbig_ff || i_ff >= hi_p) begin
               if (op_ff == OP_ADD_COLUMN) begin
                  state_in = S_IDLE;
               end else if (can_emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = (op_ff == OP_GET_ENTRY) ? row_ff : '0;
                  rsp_val_in   = '0;
                  rsp_found_in = 1'b0;
                  rsp_empty_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_sat_in   = clip_ff;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_USE;
         end
         S_USE: begin
            case (op_ff)
               OP_GET_ENTRY: begin
                  if (nz_rd.row == row_ff || last_i) begin
                     if (can_emit) begin
                        rsp_valid_in = 1'b1;
                        rsp_row_in   = row_ff;
                        rsp_found_in = nz_rd.row == row_ff;
                        rsp_val_in   = (nz_rd.row == row_ff) ? nz_val48 : '0;
                        rsp_empty_in = 1'b0;
                        rsp_last_in  = 1'b1;
                        rsp_sat_in   = clip_ff;
                        state_in     = S_IDLE;
                     end
                  end else begin
                     i_in     = i_next;
                     state_in = S_RD;
                  end
               end
               OP_GET_COLUMN: begin
                  if (can_emit) begin
                     rsp_valid_in = 1'b1;
                     rsp_row_in   = nz_rd.row;
                     rsp_val_in   = nz_val48;
                     rsp_found_in = 1'b1;
                     rsp_empty_in = 1'b0;
                     rsp_last_in  = last_i || cnt_ff == CNT_LAST;
                     rsp_sat_in   = clip_ff;
                     i_in         = i_next;
                     cnt_in       = cnt_ff + 1'b1;
                     state_in     = (last_i || cnt_ff == CNT_LAST) ? S_IDLE : S_RD;
                  end
               end
               OP_ADD_COLUMN: begin
                  if (nzrow32 < DIM) begin
                     acc_ra      = nzrow32[RW-1:0];
                     acc_addr_in = nzrow32[RW-1:0];
                     accv_in     = accvalid_ff[nzrow32[RW-1:0]];
                     state_in    = S_ADD;
                  end else begin
                     i_in     = i_next;
                     state_in = last_i ? S_IDLE : S_RD;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_ADD: begin
            acc_we                   = 1'b1;
            accvalid_in[acc_addr_ff] = 1'b1;
            clip_in                  = clip_ff || mac_res.clip;
            i_in                     = i_next;
            state_in                 = last_i ? S_IDLE : S_RD;
         end
         S_ACC: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_val_in   = (rowok_ff && accv_ff) ? acc_rdata : '0;
               rsp_found_in = 1'b0;
               rsp_empty_in = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_sat_in   = clip_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clip_ff      <= 1'b0;
         accvalid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clip_ff      <= clip_in;
         accvalid_ff  <= accvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      x_ff         <= x_in;
      colbig_ff    <= colbig_in;
      i_ff         <= i_in;
      hi_ff        <= hi_in;
      cnt_ff       <= cnt_in;
      acc_addr_ff  <= acc_addr_in;
      accv_ff      <= accv_in;
      rowok_ff     <= rowok_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_found_ff <= rsp_found_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_val_ff, rsp_row_ff};
   assign rsp_tuser  = {rsp_sat_ff, rsp_empty_ff, rsp_found_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: sv/csc_checker.sv
`include "sparse_csc_matrix_oracle_defines.svh"

module csc_checker
   import csc_pkg::*;
   (input logic                  clock,
    input logic                  reset,
    input logic                  req_tvalid,
    input logic                  req_tready,
    input logic [OP_W-1:0]       req_tuser,
    input logic                  rsp_tvalid,
    input logic                  rsp_tready,
    input logic [RSP_DATA_W-1:0] rsp_tdata,
    input logic [RSP_USER_W-1:0] rsp_tuser,
    input logic                  rsp_tlast);

   logic walk_op;

   assign walk_op = req_tuser == OP_GET_COLUMN || req_tuser == OP_ADD_COLUMN;

   `CSC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `CSC_ASSERT_IMP(a_found_not_empty, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]))
   `CSC_ASSERT_IMP(a_empty_is_last, rsp_tvalid && rsp_tuser[1], rsp_tlast)
   `CSC_ASSERT_NEXT(a_query_busy, req_tvalid && req_tready && walk_op, !req_tready)

endmodule

bind sparse_csc_matrix_oracle csc_checker u_csc_checker (.*);
